// File: rtl/uvs_pkg.sv
package uvs_pkg;

    localparam int DIV_STEPS   = 40;
    localparam int THETA_STEPS = 39;
    localparam int TEX_TAP     = 23;
    localparam int POST_STAGES = 6;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_RINGS  = 2'd1;
    localparam logic [1:0] REG_SECTS  = 2'd2;

    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

    typedef struct packed {
        logic [8:0]  rem;
        logic [31:0] quot;
        logic [7:0]  num;
        logic [16:0] tex;
    } div_word_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         q;
    } cordic_word_t;

    typedef struct packed {
        logic [15:0] corner_a;
        logic [15:0] corner_b;
        logic [15:0] corner_c;
        logic [15:0] corner_d;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
    } side_t;

    function automatic logic [31:0] atan_turn(input int unsigned idx);
        logic [31:0] v;
        unique case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/uvs_div_cell.sv
module uvs_div_cell
    import uvs_pkg::*;
#(
    parameter bit PASS = 1'b0,
    parameter bit TAP  = 1'b0
)
(
    input  logic      clk,
    input  logic      en,
    input  logic [8:0] dvsr,
    input  div_word_t din,
    output div_word_t dout
);

    div_word_t   w_next;
    logic [9:0]  t;
    logic        ge;
    logic [9:0]  rsum;
    logic [17:0] tsum;

    always_comb
    begin
        w_next = din;
        t      = {din.rem, din.num[7]};
        ge     = (t >= {1'b0, dvsr});
        if (!PASS)
        begin
            w_next.rem  = ge ? 9'(t - {1'b0, dvsr}) : t[8:0];
            w_next.quot = {din.quot[30:0], ge};
            w_next.num  = {din.num[6:0], 1'b0};
        end
        rsum = {1'b0, w_next.rem} + {1'b0, (dvsr >> 1)};
        tsum = {1'b0, w_next.quot[16:0]} + 18'(rsum >= {1'b0, dvsr});
        if (TAP)
        begin
            if ((w_next.quot[23:17] != '0) || tsum[17])
                w_next.tex = '1;
            else
                w_next.tex = tsum[16:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dout <= w_next;
    end

endmodule

// File: rtl/uvs_cordic_cell.sv
module uvs_cordic_cell
    import uvs_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic         clk,
    input  logic         en,
    input  cordic_word_t din,
    output cordic_word_t dout
);

    cordic_word_t       w_next;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] at;

    always_comb
    begin
        dx     = din.y >>> STAGE;
        dy     = din.x >>> STAGE;
        at     = signed'(atan_turn(STAGE));
        w_next = din;
        if (!din.z[31])
        begin
            w_next.x = din.x - dx;
            w_next.y = din.y + dy;
            w_next.z = din.z - at;
        end
        else
        begin
            w_next.x = din.x + dx;
            w_next.y = din.y - dy;
            w_next.z = din.z + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dout <= w_next;
    end

endmodule

// File: rtl/uv_sphere_vertex_generator.sv
// UV sphere vertex generator.
// Slave stream s_tvalid/s_tready/s_tdata carries one grid point per word:
// ring and sector index. Master stream m_tvalid/m_tready/m_tdata returns one
// word per grid point: normal, vertex, texture coordinates and the four quad
// corner indices, in input order.
// Radius, ring count and sector count are written through cfg_we/cfg_addr/
// cfg_wdata; unknown addresses are dropped. The user must write them only
// while the stream is idle; the block does not enforce it. Throughput: one
// word per cycle while the receiver accepts. Words pass the 40-cell restoring
// divider chain that forms the angles and texture coordinates, the CORDIC
// cell chain and six stages of rounding, quadrant rotation and multiplies.
// Reset clears every stage valid bit and loads radius 1.0 and 16 rings and
// sectors. When the receiver stalls the whole pipeline holds and s_tready
// falls; words in flight are kept and none are lost.
module uv_sphere_vertex_generator
    import uvs_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // ring_index, sector_index
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [223:0] m_tdata    // normal_x, normal_y, normal_z, vertex_x, vertex_y,
                                    // vertex_z, tex_u, tex_v, corner_a, corner_b,
                                    // corner_c, corner_d, zero fill
);

    localparam int LAT = DIV_STEPS + POST_STAGES + CORDIC_STAGES;

    logic [15:0] radius_reg;
    logic [8:0]  rings_reg;
    logic [8:0]  sects_reg;
    logic [8:0]  d_ring;
    logic [8:0]  d_sect;

    logic        vld_reg [LAT];
    side_t       side_reg [LAT];
    side_t       side_tex;
    logic        en;

    div_word_t   dw_r [DIV_STEPS+1];
    div_word_t   dw_s [DIV_STEPS+1];
    logic [31:0] ang_t_reg;
    logic [31:0] ang_p_reg;
    cordic_word_t cw_t [CORDIC_STAGES+1];
    cordic_word_t cw_p [CORDIC_STAGES+1];

    logic signed [31:0] ct_reg, st_reg, cp_reg, sp_reg;
    logic signed [63:0] px_reg, pz_reg;
    logic signed [15:0] ny1_reg;
    logic signed [15:0] nx_reg, ny_reg, nz_reg;
    logic signed [15:0] onx_reg, ony_reg, onz_reg;
    logic [23:0] vx_reg, vy_reg, vz_reg;

    logic [7:0]  in_r, in_s;
    logic [16:0] a_full;
    logic [16:0] n_full;
    side_t       side_in;
    logic [31:0] tq_t, tq_p;
    logic [9:0]  rs_r, rs_s;

    function automatic logic signed [15:0] clamp_n(input logic signed [17:0] v);
        logic signed [15:0] o;
        if (v > 18'sd16384)
            o = 16'sd16384;
        else if (v < -18'sd16384)
            o = -16'sd16384;
        else
            o = v[15:0];
        return o;
    endfunction

    function automatic logic [23:0] vert(input logic signed [15:0] n,
                                         input logic [15:0] rad);
        logic signed [33:0] p;
        logic signed [33:0] q;
        p = n * $signed({1'b0, rad});
        q = (p + 34'sd128) >>> 8;
        return q[23:0];
    endfunction

    assign d_ring   = (rings_reg < 9'd2) ? 9'd1 : 9'(rings_reg - 9'd1);
    assign d_sect   = (sects_reg < 9'd2) ? 9'd1 : 9'(sects_reg - 9'd1);
    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    assign in_r   = s_tdata[7:0];
    assign in_s   = s_tdata[15:8];
    assign a_full = 17'(in_r * sects_reg) + 17'(in_s);
    assign n_full = a_full + 17'(sects_reg);

    always_comb
    begin
        side_in.corner_a = a_full[15:0];
        side_in.corner_b = 16'(a_full[15:0] + 16'd1);
        side_in.corner_c = 16'(n_full[15:0] + 16'd1);
        side_in.corner_d = n_full[15:0];
        side_in.tex_u    = '0;
        side_in.tex_v    = '0;
        dw_r[0].rem  = '0;
        dw_r[0].quot = '0;
        dw_r[0].num  = in_r;
        dw_r[0].tex  = '0;
        dw_s[0].rem  = '0;
        dw_s[0].quot = '0;
        dw_s[0].num  = in_s;
        dw_s[0].tex  = '0;
    end

    always_comb
    begin
        side_tex       = side_reg[DIV_STEPS-1];
        side_tex.tex_u = dw_s[DIV_STEPS].tex;
        side_tex.tex_v = dw_r[DIV_STEPS].tex;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 16'd256;
            rings_reg  <= 9'd16;
            sects_reg  <= 9'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_RADIUS: radius_reg <= cfg_wdata;
                REG_RINGS:  rings_reg  <= cfg_wdata[8:0];
                REG_SECTS:  sects_reg  <= cfg_wdata[8:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < LAT; i++)
            begin
                if (i == DIV_STEPS)
                    side_reg[i] <= side_tex;
                else
                    side_reg[i] <= side_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        uvs_div_cell #(.PASS(k >= THETA_STEPS), .TAP(k == TEX_TAP)) u_div_r
        (
            .clk  (clk),
            .en   (en),
            .dvsr (d_ring),
            .din  (dw_r[k]),
            .dout (dw_r[k+1])
        );
        uvs_div_cell #(.PASS(1'b0), .TAP(k == TEX_TAP)) u_div_s
        (
            .clk  (clk),
            .en   (en),
            .dvsr (d_sect),
            .din  (dw_s[k]),
            .dout (dw_s[k+1])
        );
    end

    assign rs_r = {1'b0, dw_r[DIV_STEPS].rem} + {1'b0, (d_ring >> 1)};
    assign rs_s = {1'b0, dw_s[DIV_STEPS].rem} + {1'b0, (d_sect >> 1)};
    assign tq_t = ang_t_reg + 32'h2000_0000;
    assign tq_p = ang_p_reg + 32'h2000_0000;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_t_reg <= dw_r[DIV_STEPS].quot + 32'(rs_r >= {1'b0, d_ring});
            ang_p_reg <= dw_s[DIV_STEPS].quot + 32'(rs_s >= {1'b0, d_sect});
            cw_t[0].x <= GAIN_Q30;
            cw_t[0].y <= '0;
            cw_t[0].q <= tq_t[31:30];
            cw_t[0].z <= signed'(ang_t_reg - {tq_t[31:30], 30'd0});
            cw_p[0].x <= GAIN_Q30;
            cw_p[0].y <= '0;
            cw_p[0].q <= tq_p[31:30];
            cw_p[0].z <= signed'(ang_p_reg - {tq_p[31:30], 30'd0});
        end
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cordic
        uvs_cordic_cell #(.STAGE(k)) u_cell_t
        (
            .clk  (clk),
            .en   (en),
            .din  (cw_t[k]),
            .dout (cw_t[k+1])
        );
        uvs_cordic_cell #(.STAGE(k)) u_cell_p
        (
            .clk  (clk),
            .en   (en),
            .din  (cw_p[k]),
            .dout (cw_p[k+1])
        );
    end

    logic signed [32:0] ny_sum;
    logic signed [32:0] ny_sh;
    logic signed [63:0] px_sh;
    logic signed [63:0] pz_sh;

    assign ny_sum = -$signed({ct_reg[31], ct_reg}) + 33'sd32768;
    assign ny_sh  = ny_sum >>> 16;
    assign px_sh  = (px_reg + (64'sd1 <<< 45)) >>> 46;
    assign pz_sh  = (pz_reg + (64'sd1 <<< 45)) >>> 46;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unique case (cw_t[CORDIC_STAGES].q)
                2'd0:
                begin
                    ct_reg <= cw_t[CORDIC_STAGES].x;
                    st_reg <= cw_t[CORDIC_STAGES].y;
                end
                2'd1:
                begin
                    ct_reg <= -cw_t[CORDIC_STAGES].y;
                    st_reg <= cw_t[CORDIC_STAGES].x;
                end
                2'd2:
                begin
                    ct_reg <= -cw_t[CORDIC_STAGES].x;
                    st_reg <= -cw_t[CORDIC_STAGES].y;
                end
                default:
                begin
                    ct_reg <= cw_t[CORDIC_STAGES].y;
                    st_reg <= -cw_t[CORDIC_STAGES].x;
                end
            endcase
            unique case (cw_p[CORDIC_STAGES].q)
                2'd0:
                begin
                    cp_reg <= cw_p[CORDIC_STAGES].x;
                    sp_reg <= cw_p[CORDIC_STAGES].y;
                end
                2'd1:
                begin
                    cp_reg <= -cw_p[CORDIC_STAGES].y;
                    sp_reg <= cw_p[CORDIC_STAGES].x;
                end
                2'd2:
                begin
                    cp_reg <= -cw_p[CORDIC_STAGES].x;
                    sp_reg <= -cw_p[CORDIC_STAGES].y;
                end
                default:
                begin
                    cp_reg <= cw_p[CORDIC_STAGES].y;
                    sp_reg <= -cw_p[CORDIC_STAGES].x;
                end
            endcase

            px_reg  <= cp_reg * st_reg;
            pz_reg  <= sp_reg * st_reg;
            ny1_reg <= clamp_n(ny_sh[17:0]);

            nx_reg <= clamp_n(px_sh[17:0]);
            nz_reg <= clamp_n(pz_sh[17:0]);
            ny_reg <= ny1_reg;

            onx_reg <= nx_reg;
            ony_reg <= ny_reg;
            onz_reg <= nz_reg;
            vx_reg  <= vert(nx_reg, radius_reg);
            vy_reg  <= vert(ny_reg, radius_reg);
            vz_reg  <= vert(nz_reg, radius_reg);
        end
    end

    assign m_tdata = {6'd0,
                      side_reg[LAT-1].corner_d,
                      side_reg[LAT-1].corner_c,
                      side_reg[LAT-1].corner_b,
                      side_reg[LAT-1].corner_a,
                      side_reg[LAT-1].tex_v,
                      side_reg[LAT-1].tex_u,
                      vz_reg, vy_reg, vx_reg,
                      onz_reg, ony_reg, onx_reg};

endmodule
